// ----- src/cfmb_pkg.sv -----
// Shared types, constants and the CRC byte update for the framed message builder.
package cfmb_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    // Header bytes F0 9F 92 A5, first byte in the low bits.
    localparam logic [31:0] FRAME_MAGIC = 32'hA592_9FF0;
    localparam logic [3:0]  FULL_WORD   = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HDR  = 3'b010,
        ST_PAY  = 3'b100
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // take one payload byte
        logic hdr;      // emit header word, start payload read
        logic pay;      // emit one payload word
        logic clear;    // frame done, back to initial state
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;    // no payload bytes stored
        logic at_last;  // current payload word is the final one
    } dp_sts_t;

    // CRC-16, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/cfmb_ctrl.sv -----
// Controller state machine: byte collection, header word, payload words.
module cfmb_ctrl
    import cfmb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    end_of_payload,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && end_of_payload)
                    state_next = ST_HDR;
            end
            ST_HDR:
            begin
                cmd.hdr = 1'b1;
                if (sts.empty)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_PAY;
            end
            ST_PAY:
            begin
                cmd.pay = 1'b1;
                if (sts.at_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- src/cfmb_datapath.sv -----
// Datapath: running CRC, byte count, word-wide payload memory, output registers.
module cfmb_datapath
    import cfmb_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  payload_byte,
    output dp_sts_t     sts,
    output logic        word_strobe,
    output logic [63:0] frame_word,
    output logic [3:0]  valid_bytes,
    output logic        overflow_flag,
    output logic        last_word
);

    localparam int WORDS = (MAX_PAYLOAD_BYTES + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD_BYTES);

    // Payload memory, eight bytes per word, byte-lane writes.
    logic [63:0] mem [WORDS];

    logic [15:0]   crc_reg,   crc_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg,  drop_next;
    logic [AW-1:0] widx_reg,  widx_next;
    logic [63:0]   rd_data_reg;

    logic          strobe_reg;
    logic [63:0]   word_reg;
    logic [3:0]    valid_reg;
    logic          ovf_reg;
    logic          last_reg;

    logic          full;
    logic          store;
    logic [AW-1:0] wr_addr;
    logic [2:0]    wr_lane;
    logic [CW-1:0] tail;
    logic [AW-1:0] last_idx;
    logic [3:0]    tail_bytes;
    logic [AW-1:0] rd_addr;
    logic [3:0]    pay_valid;
    logic [63:0]   pay_word;

    assign full       = (count_reg == CNT_MAX);
    assign store      = cmd.accept && !full;
    assign wr_addr    = AW'(count_reg >> 3);
    assign wr_lane    = count_reg[2:0];
    assign tail       = count_reg - CW'(1);
    assign last_idx   = AW'(tail >> 3);
    assign tail_bytes = {1'b0, tail[2:0]} + 4'd1;

    assign sts.empty   = (count_reg == '0);
    assign sts.at_last = (widx_reg == last_idx);

    // Next word to read: first word in header cycle, else the following one (held at the last).
    assign rd_addr = cmd.hdr ? '0 : (sts.at_last ? widx_reg : widx_reg + AW'(1));

    assign pay_valid = sts.at_last ? tail_bytes : FULL_WORD;

    // Zero the lanes above the valid count.
    always_comb
    begin
        for (int lane = 0; lane < 8; lane++)
        begin
            if (4'(lane) < pay_valid)
                pay_word[lane*8 +: 8] = rd_data_reg[lane*8 +: 8];
            else
                pay_word[lane*8 +: 8] = 8'h00;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        widx_next  = widx_reg;
        if (store)
        begin
            crc_next   = crc_byte(crc_reg, payload_byte);
            count_next = count_reg + CW'(1);
        end
        if (cmd.accept && full)
            drop_next = 1'b1;
        if (cmd.hdr)
            widx_next = '0;
        else if (cmd.pay)
            widx_next = rd_addr;
        if (cmd.clear)
        begin
            crc_next   = CRC_INIT;
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_INIT;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            widx_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            widx_reg   <= widx_next;
            strobe_reg <= cmd.hdr || cmd.pay;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            mem[wr_addr][wr_lane*8 +: 8] <= payload_byte;
        if (cmd.hdr || cmd.pay)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr)
        begin
            word_reg  <= {16'(count_reg), crc_reg, FRAME_MAGIC};
            valid_reg <= FULL_WORD;
            ovf_reg   <= drop_reg;
            last_reg  <= sts.empty;
        end
        else if (cmd.pay)
        begin
            word_reg  <= pay_word;
            valid_reg <= pay_valid;
            ovf_reg   <= 1'b0;
            last_reg  <= sts.at_last;
        end
    end

    assign word_strobe   = strobe_reg;
    assign frame_word    = word_reg;
    assign valid_bytes   = valid_reg;
    assign overflow_flag = ovf_reg;
    assign last_word     = last_reg;

endmodule

// ----- src/crc_framed_message_builder.sv -----
// Top level of the CRC-16 framed message builder.
//
// Input channel: one payload byte per transaction. A transaction is taken at
// a rising edge with start high and busy low; end_of_payload marks the final
// byte of the message. While bytes are collected busy stays low, so one byte
// can be taken every cycle. Each byte is written into an 8-byte-wide payload
// memory and folded into a CRC-16 (init FFFF, poly 1021, MSB first).
// Bytes past MAX_PAYLOAD_BYTES are dropped and remembered as overflow.
//
// Output channel: after the final byte the frame leaves as 64-bit words, one
// per cycle, each flagged by word_strobe for exactly one cycle; the receiver
// cannot stall. Word 0 holds the header F0 9F 92 A5, CRC and byte count, plus
// the overflow flag; words 1.. hold the payload, zero-filled above valid_bytes.
// The header word is registered in the header state that follows the final byte,
// and the payload words come out back to back, one word per cycle from the
// single read port of the payload memory. busy stays high through the header and
// payload states; the next message can start while the last word is on the ports.
// Reset (rst_n low, asynchronous) clears the CRC, count, drop flag, strobe and
// state; the memory is not cleared, only bytes written in the frame are read.
module crc_framed_message_builder
    import cfmb_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  payload_byte,
    input  logic        end_of_payload,
    output logic        word_strobe,
    output logic [63:0] frame_word,
    output logic [3:0]  valid_bytes,
    output logic        overflow_flag,
    output logic        last_word
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    cfmb_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .end_of_payload (end_of_payload),
        .sts            (sts),
        .cmd            (cmd),
        .busy           (busy)
    );

    cfmb_datapath #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .payload_byte  (payload_byte),
        .sts           (sts),
        .word_strobe   (word_strobe),
        .frame_word    (frame_word),
        .valid_bytes   (valid_bytes),
        .overflow_flag (overflow_flag),
        .last_word     (last_word)
    );

`ifndef SYNTHESIS
    // A final byte always launches frame emission.
    a_last_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && end_of_payload |=> busy)
        else $error("final byte did not start emission");

    // Frame words are back to back until the last one.
    a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        word_strobe && !last_word |=> word_strobe)
        else $error("gap inside frame");

    // Overflow only on the first word of a frame.
    a_overflow_first: assert property (@(posedge clk) disable iff (!rst_n)
        word_strobe && !last_word |=> !overflow_flag)
        else $error("overflow flag on a later word");

    // Valid byte count in range.
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_strobe |-> (valid_bytes != 4'd0) && (valid_bytes <= FULL_WORD))
        else $error("valid_bytes out of range");
`endif

endmodule

// ----- tb/crc_framed_message_builder_test.sv -----
// Self-checking testbench for the CRC-16 framed message builder.
module crc_framed_message_builder_test;

    import cfmb_pkg::*;

    localparam int PAYLOAD_CAP = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  payload_byte;
    logic        end_of_payload;
    logic        word_strobe;
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        overflow_flag;
    logic        last_word;

    // One frame word as the block should emit it.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        ovf;
        logic        last;
    } frame_word_s;

    // Payload patterns for a message.
    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_COUNT
    } fill_t;

    // Mirrors the builder: running CRC, stored bytes, count and drop flag.
    // Each accepted byte transaction goes through take_byte(); the final byte
    // of a message expands into the queue of frame words still owed.
    class frame_checker;
        logic [15:0]  crc;
        logic [7:0]   store [PAYLOAD_CAP];
        int unsigned  count;
        bit           dropped;
        frame_word_s  owed [$];
        int unsigned  errors;
        int unsigned  reports;

        function new();
            errors  = 0;
            reports = 0;
            restart();
        endfunction

        function void restart();
            crc     = CRC_INIT;
            count   = 0;
            dropped = 1'b0;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            repeat (8)
            begin
                if (r[15])
                    r = {r[14:0], 1'b0} ^ CRC_POLY;
                else
                    r = {r[14:0], 1'b0};
            end
            return r;
        endfunction

        function void take_byte(logic [7:0] b, logic eop);
            logic [7:0]  fb [$];
            frame_word_s w;
            int unsigned pos;
            int unsigned left;
            if (count < PAYLOAD_CAP)
            begin
                store[count] = b;
                crc = crc_step(crc, b);
                count++;
            end
            else
                dropped = 1'b1;   // buffer full: byte lost, CRC and count untouched
            if (!eop)
                return;
            fb.push_back(FRAME_MAGIC[7:0]);
            fb.push_back(FRAME_MAGIC[15:8]);
            fb.push_back(FRAME_MAGIC[23:16]);
            fb.push_back(FRAME_MAGIC[31:24]);
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            fb.push_back(8'(count));
            fb.push_back(8'(count >> 8));
            for (int i = 0; i < count; i++)
                fb.push_back(store[i]);
            for (pos = 0; pos < fb.size(); pos += 8)
            begin
                left     = fb.size() - pos;
                w.data   = '0;
                w.nbytes = (left >= 8) ? FULL_WORD : 4'(left);
                for (int i = 0; i < w.nbytes; i++)
                    w.data[8*i +: 8] = fb[pos + i];
                w.ovf  = (pos == 0) && dropped;
                w.last = (pos + 8 >= fb.size());
                owed.push_back(w);
            end
            restart();
        endfunction

        function void check_word(logic [63:0] data, logic [3:0] nbytes,
                                 logic ovf, logic last);
            frame_word_s w;
            if (owed.size() == 0)
            begin
                errors++;
                if (reports < 10)
                begin
                    reports++;
                    $display("unexpected frame word %h (valid %0d), no frame pending",
                             data, nbytes);
                end
                return;
            end
            w = owed.pop_front();
            if (data !== w.data || nbytes !== w.nbytes || ovf !== w.ovf ||
                last !== w.last)
            begin
                errors++;
                if (reports < 10)
                begin
                    reports++;
                    $display("frame word mismatch: exp data %h valid %0d ovf %b last %b",
                             w.data, w.nbytes, w.ovf, w.last);
                    $display("                     got data %h valid %0d ovf %b last %b",
                             data, nbytes, ovf, last);
                end
            end
        endfunction
    endclass

    frame_checker chk = new();

    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned rand_items = 0;

    crc_framed_message_builder #(
        .MAX_PAYLOAD_BYTES(PAYLOAD_CAP)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .payload_byte   (payload_byte),
        .end_of_payload (end_of_payload),
        .word_strobe    (word_strobe),
        .frame_word     (frame_word),
        .valid_bytes    (valid_bytes),
        .overflow_flag  (overflow_flag),
        .last_word      (last_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung block or a lost frame word ends up here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: the strobe marks one word for one cycle, no backpressure.
    always @(posedge clk)
    begin
        if (rst_n && word_strobe)
            chk.check_word(frame_word, valid_bytes, overflow_flag, last_word);
    end

    // Idle cycles; the data lines carry junk while start is low.
    task automatic idle_cycles(input int unsigned n);
        repeat (n)
        begin
            start          <= 1'b0;
            payload_byte   <= 8'($urandom);
            end_of_payload <= 1'($urandom);
            @(negedge clk);
        end
    endtask

    // Bursts of back-to-back transactions separated by random gaps; a quarter
    // of the bursts follow the previous one with no gap at all.
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 7));
        end
        burst_left--;
    endtask

    // One byte transaction. Entered at a falling edge, start held until the
    // rising edge where busy is low, left at the next falling edge.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        pace();
        start          <= 1'b1;
        payload_byte   <= b;
        end_of_payload <= eop;
        do
            @(posedge clk);
        while (busy);
        chk.take_byte(b, eop);
        @(negedge clk);
    endtask

    task automatic send_message(input int unsigned len, input fill_t fill);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++)
        begin
            unique case (fill)
                FILL_ZERO:   b = 8'h00;
                FILL_ONES:   b = 8'hFF;
                FILL_COUNT:  b = 8'(i);
                FILL_RANDOM: b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Hold the sender off until every owed frame word has been seen.
    task automatic drain();
        start <= 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned len;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        payload_byte   = 8'h00;
        end_of_payload = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: one-byte messages at both byte extremes, a message that
        // leaves a short last word, one that fills it exactly, one that spills.
        send_message(1, FILL_ZERO);
        send_message(1, FILL_ONES);
        send_message(7, FILL_ONES);
        send_message(8, FILL_COUNT);
        drain();
        send_message(9, FILL_RANDOM);

        // Buffer filled to the brim, then a tail (final byte included) that
        // overflows it: the longest frame, with the overflow flag.
        drain();
        send_message(PAYLOAD_CAP + 4, FILL_RANDOM);

        // Random messages, mostly short, now and then up to 64 bytes.
        while (rand_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(25, 64);
            else
                len = $urandom_range(1, 24);
            send_message(len, FILL_RANDOM);
            rand_items += len;
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (10) @(posedge clk);
        if (chk.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
src/cfmb_pkg.sv
src/cfmb_ctrl.sv
src/cfmb_datapath.sv
src/crc_framed_message_builder.sv
tb/crc_framed_message_builder_test.sv
